>>> rtl/core/itra_pkg.sv
`default_nettype none
package itra_pkg;

	localparam int VALUE_BITS = 32;
	localparam int MAG_BITS = VALUE_BITS - 1;
	localparam int MAX_DIGITS = VALUE_BITS - 1;
	localparam int CNT_BITS = $clog2(MAX_DIGITS);
	localparam int STEP_BITS = $clog2(MAG_BITS);
	localparam int RADIX_BITS = 6;
	localparam int DIGIT_BITS = 6;
	localparam int ASCII_BITS = 7;

	localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(10);
	localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
	localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(36);
	localparam logic [ASCII_BITS-1:0] ASCII_ZERO = ASCII_BITS'(48);
	localparam logic [ASCII_BITS-1:0] ASCII_UPPER_A = ASCII_BITS'(65);
	localparam logic [DIGIT_BITS-1:0] DECIMAL_TEN = DIGIT_BITS'(10);

	typedef struct packed {
		logic                  done;
		logic [MAG_BITS-1:0]   quot;
		logic [DIGIT_BITS-1:0] rem;
	} div_res_t;

	function automatic logic [RADIX_BITS-1:0] sat_radix(input logic [RADIX_BITS-1:0] r);
		logic [RADIX_BITS-1:0] res;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end else begin
			res = r;
		end
		return res;
	endfunction

	function automatic logic [ASCII_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
		logic [ASCII_BITS-1:0] res;
		if (d < DECIMAL_TEN) begin
			res = ASCII_ZERO + ASCII_BITS'(d);
		end else begin
			res = ASCII_UPPER_A + ASCII_BITS'(d - DECIMAL_TEN);
		end
		return res;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/integer_to_radix_ascii_unit.sv
// Converts one signed word to ASCII digits, most significant first.
// A zero or negative word gives one empty result in the cycle after acceptance.
// Otherwise the shared bit-serial divider produces each of the D digits in turn,
// then the digits come out one per cycle; the unit stays busy throughout.
// The receiver cannot stall; results are strobed for exactly one cycle.
// Asynchronous active-low reset sets the radix to ten and returns the sequencer to idle.
`default_nettype none
module integer_to_radix_ascii_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output      logic                            busy,
	input  wire logic signed [itra_pkg::VALUE_BITS-1:0] value,
	input  wire logic                            cfg_valid,
	output      logic                            cfg_ready,
	input  wire logic [itra_pkg::RADIX_BITS-1:0] cfg_data,
	output      logic                            result_valid,
	output      logic [itra_pkg::ASCII_BITS-1:0] ascii_digit,
	output      logic                            last_digit,
	output      logic                            empty_flag
);
	import itra_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]            state_q;
	logic [RADIX_BITS-1:0] radix_q;
	logic [RADIX_BITS-1:0] eff_radix_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [CNT_BITS-1:0]   ptr_q;
	logic                  emit_v_s1;
	logic                  last_s1;
	logic                  valid_q;
	logic [ASCII_BITS-1:0] ascii_q;
	logic                  last_q;
	logic                  empty_q;

	logic                  accept;
	logic                  is_empty;
	logic                  div_go;
	logic [MAG_BITS-1:0]   div_dividend;
	div_res_t              div_res;
	logic                  conv_end;
	logic                  ram_we;
	logic [DIGIT_BITS-1:0] ram_rdata;

	assign accept = start && !busy;
	assign is_empty = value[VALUE_BITS-1] || (value == '0);
	assign busy = (state_q != ST_IDLE) || emit_v_s1;
	assign cfg_ready = 1'b1;

	assign conv_end = (div_res.quot == '0) || (cnt_q == CNT_BITS'(MAX_DIGITS - 1));
	assign ram_we = (state_q == ST_DIV) && div_res.done;
	assign div_go = (accept && !is_empty) || (ram_we && !conv_end);
	assign div_dividend = accept ? value[MAG_BITS-1:0] : div_res.quot;

	itra_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_dividend),
		.divisor  (accept ? sat_radix(radix_q) : eff_radix_q),
		.res      (div_res)
	);

	itra_ram #(
		.WIDTH (DIGIT_BITS),
		.DEPTH (MAX_DIGITS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q),
		.wdata (div_res.rem),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			radix_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			ptr_q <= '0;
			emit_v_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			emit_v_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !is_empty) begin
						cnt_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_res.done) begin
						cnt_q <= cnt_q + 1'b1;
						if (conv_end) begin
							ptr_q <= cnt_q;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					emit_v_s1 <= 1'b1;
					last_s1 <= (ptr_q == '0);
					if (ptr_q == '0) begin
						cnt_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q - 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			eff_radix_q <= sat_radix(radix_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= emit_v_s1 || (accept && is_empty);
		end
	end

	always_ff @(posedge clk) begin
		if (emit_v_s1) begin
			ascii_q <= digit_to_ascii(ram_rdata);
			last_q <= last_s1;
			empty_q <= 1'b0;
		end else begin
			ascii_q <= '0;
			last_q <= 1'b1;
			empty_q <= 1'b1;
		end
	end

	assign result_valid = valid_q;
	assign ascii_digit = ascii_q;
	assign last_digit = last_q;
	assign empty_flag = empty_q;

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && empty_flag |-> last_digit)
		else $error("Empty result without the last mark.");

	a_empty_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_empty |=> result_valid && empty_flag)
		else $error("Empty word did not give its result in the next cycle.");

	a_digit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !is_empty |=> busy && !result_valid)
		else $error("Conversion did not hold the unit busy.");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == ST_DIV)
		else $error("Divider finished outside the divide phase.");

	a_digit_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !empty_flag |-> ascii_digit >= ASCII_ZERO)
		else $error("Digit result below the digit zero code.");

endmodule
`default_nettype wire

>>> rtl/core/itra_ram.sv
`default_nettype none
module itra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/core/itra_div.sv
`default_nettype none
module itra_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            go,
	input  wire logic [itra_pkg::MAG_BITS-1:0]   dividend,
	input  wire logic [itra_pkg::RADIX_BITS-1:0] divisor,
	output      itra_pkg::div_res_t              res
);
	import itra_pkg::*;

	// Restoring division, one quotient bit per cycle; the dividend register
	// shifts left and collects the quotient bits at its low end.
	logic [MAG_BITS-1:0]   quot_q;
	logic [DIGIT_BITS-1:0] rem_q;
	logic [RADIX_BITS-1:0] div_q;
	logic [STEP_BITS-1:0]  step_q;
	logic                  run_q;
	logic                  done_q;
	logic [DIGIT_BITS:0]   trial;
	logic                  fits;
	logic [DIGIT_BITS:0]   diff;

	assign trial = {rem_q, quot_q[MAG_BITS-1]};
	assign fits = trial >= {1'b0, div_q};
	assign diff = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				if (step_q == STEP_BITS'(MAG_BITS - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quot_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			quot_q <= {quot_q[MAG_BITS-2:0], fits};
			rem_q <= fits ? diff[DIGIT_BITS-1:0] : trial[DIGIT_BITS-1:0];
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;
	assign res.rem = rem_q;

endmodule
`default_nettype wire
